### sv/correlate_2d_clamped_window_unit_assert.svh
// ----------------------------------------------------------------------------
// correlate_2d_clamped_window_unit assertion macros
// Concurrent assertion wrappers used by the checker file c2cw_checker.sv.
// ----------------------------------------------------------------------------
`ifndef CORRELATE_2D_CLAMPED_WINDOW_UNIT_ASSERT_SVH
`define CORRELATE_2D_CLAMPED_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define C2CW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2cw checker: same-cycle property failed");

// next-cycle implication, disabled in reset
`define C2CW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2cw checker: next-cycle property failed");

`endif

### sv/c2cw_pkg.sv
// ----------------------------------------------------------------------------
// c2cw_pkg
// Types and fixed constants of the clamped-window 2D correlation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package c2cw_pkg;

    localparam int DIM_W      = 10;
    localparam int KSIZE_W    = 3;
    localparam int COORD_W    = 9;
    localparam int PIXEL_W    = 8;
    localparam int CIDX_W     = 3;
    localparam int COEF_W     = 16;
    localparam int RESULT_W   = 16;
    localparam int FRAC_W     = 14;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 10'd512;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 10'd512;
    localparam logic [KSIZE_W-1:0] KSIZE_RESET  = 3'd3;

    localparam logic signed [RESULT_W-1:0] RESULT_MAX = 16'sh7fff;
    localparam logic signed [RESULT_W-1:0] RESULT_MIN = 16'sh8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_PIXEL   = 2'd0,
        CMD_COEF    = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_KERNEL_SIZE  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [COORD_W-1:0]       x;
        logic [COORD_W-1:0]       y;
        logic [PIXEL_W-1:0]       pixel;
        logic [CIDX_W-1:0]        coef_i;
        logic [CIDX_W-1:0]        coef_j;
        logic signed [COEF_W-1:0] coef;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result;
        logic                       saturated;
    } out_item_t;

    typedef struct packed {
        logic wr_pixel;
        logic wr_coef;
        logic start;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic no_taps;
        logic tap_last;
        logic pipe_busy;
        logic out_busy;
    } ctrl_status_t;

endpackage

`default_nettype wire

### sv/correlate_2d_clamped_window_unit.sv
// ----------------------------------------------------------------------------
// correlate_2d_clamped_window_unit
// 2D correlation with clamp-to-edge borders over a stored frame.
//
// Input channel (in_valid/in_ready/in_data) carries one command per
// transaction: write a pixel, write a kernel coefficient, or compute the
// correlation at a point. Writes may follow each other every cycle while
// no compute is in progress. A compute walks the n x n kernel taps (none
// with an empty kernel), one tap per cycle through the single read port of
// the frame memory, then drains the clamp, address, read, multiply and
// accumulate stages; the next transaction is taken from the cycle in which
// the result is registered. Other commands give no result.
// Output channel (out_valid/out_ready/out_data) is driven from a register;
// while a result waits, writes are still accepted, and a following compute
// holds its finished sum until the register is free.
// Configuration (cfg_wr_en/cfg_index/cfg_data) is to be written while idle;
// the block itself does not enforce it. Reset clears control state and
// restores 512 x 512 with a 3 x 3 kernel; frame and kernel memories are
// not cleared and read as garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module correlate_2d_clamped_window_unit #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire c2cw_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output c2cw_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [c2cw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c2cw_pkg::CFG_DATA_W-1:0] cfg_data
);

    c2cw_pkg::ctrl_cmd_t    ctrl;
    c2cw_pkg::ctrl_status_t status;

    c2cw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_data.cmd),
        .status   (status),
        .ctrl     (ctrl)
    );

    c2cw_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### sv/c2cw_ctrl.sv
// ----------------------------------------------------------------------------
// c2cw_ctrl
// Sequencer: accepts transactions, walks the kernel taps, drains the
// datapath pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cw_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [c2cw_pkg::CMD_W-1:0] in_cmd,
    input  wire c2cw_pkg::ctrl_status_t    status,
    output c2cw_pkg::ctrl_cmd_t            ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;
    logic   accept;

    always_comb
    begin
        accept          = in_valid && ready_reg;
        ctrl.wr_pixel   = accept && (in_cmd == c2cw_pkg::CMD_PIXEL);
        ctrl.wr_coef    = accept && (in_cmd == c2cw_pkg::CMD_COEF);
        ctrl.start      = accept && (in_cmd == c2cw_pkg::CMD_COMPUTE);
        ctrl.issue      = (state_reg == ST_ISSUE);
        ctrl.finish     = (state_reg == ST_DRAIN) && !status.pipe_busy && !status.out_busy;
        state_next      = state_reg;
        ready_next      = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready_next = 1'b1;
                if (ctrl.start)
                begin
                    ready_next = 1'b0;
                    state_next = status.no_taps ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (status.tap_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (ctrl.finish)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

### sv/c2cw_datapath.sv
// ----------------------------------------------------------------------------
// c2cw_datapath
// Configuration registers, frame and kernel memories, tap counters, the
// clamp / address / read / multiply / accumulate pipeline and the output
// register with truncation and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module c2cw_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_KERNEL = 7
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire c2cw_pkg::in_item_t             in_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [c2cw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [c2cw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire c2cw_pkg::ctrl_cmd_t            ctrl,
    output c2cw_pkg::ctrl_status_t              status,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output c2cw_pkg::out_item_t                 out_data
);

    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIMW    = $clog2(MAX_DIM + 1);
    localparam int CW      = ((DIMW > c2cw_pkg::DIM_W) ? DIMW : c2cw_pkg::DIM_W) + 2;
    localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;
    localparam int KAW     = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int KW      = $clog2(MAX_KERNEL + 1);
    localparam int IW      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PW      = c2cw_pkg::COEF_W + c2cw_pkg::PIXEL_W + 1;
    localparam int ACW     = ((PW + KAW) > 31) ? (PW + KAW) : 31;
    localparam int QW      = ACW - c2cw_pkg::FRAC_W;
    localparam logic signed [ACW-1:0] ROUND_BIAS = ACW'((1 << c2cw_pkg::FRAC_W) - 1);

    logic [c2cw_pkg::DIM_W-1:0]   width_reg;
    logic [c2cw_pkg::DIM_W-1:0]   height_reg;
    logic [c2cw_pkg::KSIZE_W-1:0] ksize_reg;

    logic [DIMW-1:0] eff_w;
    logic [DIMW-1:0] eff_h;
    logic [KW-1:0]   eff_n;
    logic [KW-1:0]   centre;
    logic [KW-1:0]   last_idx;

    logic [c2cw_pkg::COORD_W-1:0] x_reg;
    logic [c2cw_pkg::COORD_W-1:0] y_reg;
    logic [IW-1:0]                i_reg;
    logic [IW-1:0]                j_reg;

    logic signed [CW-1:0] xr;
    logic signed [CW-1:0] yr;
    logic [XW-1:0]        xs_next;
    logic [YW-1:0]        ys_next;
    logic [KAW-1:0]       ka_next;

    logic                 v1_reg;
    logic                 v2_reg;
    logic                 v3_reg;
    logic                 v4_reg;
    logic [XW-1:0]        xs1_reg;
    logic [YW-1:0]        ys1_reg;
    logic [KAW-1:0]       ka1_reg;
    logic [AW-1:0]        fa2_reg;
    logic [KAW-1:0]       ka2_reg;
    logic [c2cw_pkg::PIXEL_W-1:0]      pix3_reg;
    logic signed [c2cw_pkg::COEF_W-1:0] coef3_reg;
    logic signed [PW-1:0]  prod4_reg;
    logic signed [ACW-1:0] acc_reg;

    logic [c2cw_pkg::PIXEL_W-1:0]       frame_mem [DEPTH];
    logic signed [c2cw_pkg::COEF_W-1:0] kernel_mem [KDEPTH];

    logic            pix_we;
    logic [AW-1:0]   pix_wa;
    logic            coef_we;
    logic [KAW-1:0]  coef_wa;

    logic signed [ACW-1:0] adj;
    logic signed [ACW-1:0] shifted;
    logic signed [QW-1:0]  q;
    logic                  sat_hi;
    logic                  sat_lo;

    logic                  out_valid_reg;
    c2cw_pkg::out_item_t   out_data_reg;
    c2cw_pkg::out_item_t   out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= c2cw_pkg::WIDTH_RESET;
            height_reg <= c2cw_pkg::HEIGHT_RESET;
            ksize_reg  <= c2cw_pkg::KSIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                c2cw_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                c2cw_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                c2cw_pkg::CFG_KERNEL_SIZE:  ksize_reg  <= cfg_data[c2cw_pkg::KSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (width_reg == '0)
            eff_w = DIMW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = DIMW'(MAX_WIDTH);
        else
            eff_w = DIMW'(width_reg);

        priority if (height_reg == '0)
            eff_h = DIMW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_h = DIMW'(MAX_HEIGHT);
        else
            eff_h = DIMW'(height_reg);

        priority if (32'(ksize_reg) > 32'(MAX_KERNEL))
            eff_n = KW'(MAX_KERNEL);
        else
            eff_n = KW'(ksize_reg);
    end

    assign centre   = eff_n >> 1;
    assign last_idx = eff_n - KW'(1);

    always_comb
    begin
        xr = $signed(CW'(x_reg)) - $signed(CW'(centre)) + $signed(CW'(i_reg));
        yr = $signed(CW'(y_reg)) - $signed(CW'(centre)) + $signed(CW'(j_reg));

        priority if (xr < 0)
            xs_next = '0;
        else if (xr >= $signed(CW'(eff_w)))
            xs_next = XW'(eff_w - DIMW'(1));
        else
            xs_next = XW'(xr);

        priority if (yr < 0)
            ys_next = '0;
        else if (yr >= $signed(CW'(eff_h)))
            ys_next = YW'(eff_h - DIMW'(1));
        else
            ys_next = YW'(yr);

        ka_next = KAW'(i_reg) * KAW'(MAX_KERNEL) + KAW'(j_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (ctrl.start)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else if (ctrl.issue)
        begin
            if (KW'(j_reg) == last_idx)
            begin
                j_reg <= '0;
                i_reg <= i_reg + IW'(1);
            end
            else
            begin
                j_reg <= j_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= in_data.x;
            y_reg <= in_data.y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        xs1_reg   <= xs_next;
        ys1_reg   <= ys_next;
        ka1_reg   <= ka_next;
        fa2_reg   <= AW'(ys1_reg) * AW'(MAX_WIDTH) + AW'(xs1_reg);
        ka2_reg   <= ka1_reg;
        prod4_reg <= coef3_reg * $signed({1'b0, pix3_reg});
    end

    always_comb
    begin
        pix_we  = ctrl.wr_pixel
                  && (32'(in_data.x) < 32'(MAX_WIDTH))
                  && (32'(in_data.y) < 32'(MAX_HEIGHT));
        pix_wa  = AW'(in_data.y) * AW'(MAX_WIDTH) + AW'(in_data.x);
        coef_we = ctrl.wr_coef
                  && (32'(in_data.coef_i) < 32'(MAX_KERNEL))
                  && (32'(in_data.coef_j) < 32'(MAX_KERNEL));
        coef_wa = KAW'(in_data.coef_i) * KAW'(MAX_KERNEL) + KAW'(in_data.coef_j);
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            frame_mem[pix_wa] <= in_data.pixel;
        end
        pix3_reg <= frame_mem[fa2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            kernel_mem[coef_wa] <= in_data.coef;
        end
        coef3_reg <= kernel_mem[ka2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            acc_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_reg <= acc_reg + ACW'(prod4_reg);
        end
    end

    always_comb
    begin
        adj     = acc_reg + (acc_reg[ACW-1] ? ROUND_BIAS : '0);
        shifted = adj >>> c2cw_pkg::FRAC_W;
        q       = QW'(shifted);
        sat_hi  = q > $signed(QW'(c2cw_pkg::RESULT_MAX));
        sat_lo  = q < $signed(QW'(c2cw_pkg::RESULT_MIN));
        priority if (sat_hi)
            out_data_next.result = c2cw_pkg::RESULT_MAX;
        else if (sat_lo)
            out_data_next.result = c2cw_pkg::RESULT_MIN;
        else
            out_data_next.result = q[c2cw_pkg::RESULT_W-1:0];
        out_data_next.saturated = sat_hi || sat_lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        status.no_taps   = (eff_n == '0);
        status.tap_last  = (KW'(i_reg) == last_idx) && (KW'(j_reg) == last_idx);
        status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
        status.out_busy  = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### sv/c2cw_checker.sv
// ----------------------------------------------------------------------------
// c2cw_checker
// Port-level checks of the correlation unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "correlate_2d_clamped_window_unit_assert.svh"

module c2cw_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire c2cw_pkg::in_item_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire c2cw_pkg::out_item_t out_data
);

    logic compute_txn;
    logic other_txn;

    assign compute_txn = in_valid && in_ready && (in_data.cmd == c2cw_pkg::CMD_COMPUTE);
    assign other_txn   = in_valid && in_ready && (in_data.cmd != c2cw_pkg::CMD_COMPUTE);

    `C2CW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `C2CW_ASSERT_NEXT(a_compute_busy, clk, rst_n, compute_txn, !in_ready && !$rose(out_valid))
    `C2CW_ASSERT_NEXT(a_write_ready, clk, rst_n, other_txn, in_ready)
    `C2CW_ASSERT_IMPL(a_result_release, clk, rst_n, $rose(out_valid), $rose(in_ready))

endmodule

bind correlate_2d_clamped_window_unit c2cw_checker u_c2cw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
